// ----- design/assert_macros.svh -----
// Assertion helper macros for the sensor frame decoder.
// Uses the including module's clk and rst_n signals.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TH_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define TH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- design/thfd_pkg.sv -----
// Shared types, constants and the CRC-8 step function for the frame decoder.
// No dependencies.
package thfd_pkg;

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // Byte positions within a six-byte frame.
  localparam logic [2:0] POS_T_HI  = 3'd0;
  localparam logic [2:0] POS_T_LO  = 3'd1;
  localparam logic [2:0] POS_T_CRC = 3'd2;
  localparam logic [2:0] POS_H_HI  = 3'd3;
  localparam logic [2:0] POS_H_LO  = 3'd4;
  localparam logic [2:0] POS_H_CRC = 3'd5;

  localparam logic [14:0] TEMP_SCALE  = 15'd17500;
  localparam logic [14:0] HUMID_SCALE = 15'd10000;
  localparam logic [14:0] TEMP_OFFSET = 15'd4500;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TEMP_CRC  = 2'd1,
    ST_HUMID_CRC = 2'd2
  } status_t;

  typedef struct packed {
    logic        last;        // current byte closes the frame
    status_t     status;
    logic [15:0] temp_word;
    logic [15:0] humid_word;
  } frame_info_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ----- design/temp_humidity_frame_decoder.sv -----
// Top level of the sensor frame decoder: input register, frame tracker,
// scalers and result register. Depends on thfd_pkg, thfd_frame_ctrl, thfd_scale.
//
//   channel | handshake             | payload
//   --------+-----------------------+------------------------------------------
//   in      | in_valid / in_stall   | in_rx_byte[7:0], in_frame_start
//   out     | out_valid / out_stall | out_temp_centideg[14:0] (signed),
//           |                       | out_humid_centipct[13:0], out_frame_status
//
// One byte beat per cycle while the input is not stalled; a byte is held in the
// input register and its result in the result register, with the CRC update
// and the 16x15 scale multiply that sit between the two registers.
// Only the sixth byte of a frame makes a result beat; other bytes leave none.
// Reset (rst_n low, synchronous) empties both registers and returns the byte
// position to the frame start with the CRC at 0xFF.
// A stalled result holds; the input register still drains bytes that make
// no result, and stalls only when a closing byte meets a stalled result.
`include "assert_macros.svh"

module temp_humidity_frame_decoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  input  logic               in_frame_start,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [14:0] out_temp_centideg,
  output logic [13:0]        out_humid_centipct,
  output logic [1:0]         out_frame_status
);
  import thfd_pkg::*;

  // Input register.
  logic        s1_valid_r, s1_valid_nxt;
  logic [7:0]  s1_byte_r;
  logic        s1_start_r;

  // Result register.
  logic        out_valid_r, out_valid_nxt;
  logic [14:0] temp_r;
  logic [13:0] humid_r;
  status_t     status_r;

  frame_info_t info;
  logic        step;
  logic        out_free;
  logic        in_take;
  logic        frame_ok;
  logic [14:0] temp_q;
  logic [14:0] humid_q;

  // Advance the held byte unless it closes a frame and the result slot is busy.
  assign out_free = !out_valid_r || !out_stall;
  assign step     = s1_valid_r && (!info.last || out_free);
  assign in_stall = s1_valid_r && !step;
  assign in_take  = in_valid && !in_stall;

  thfd_frame_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_i  (step),
    .byte_i  (s1_byte_r),
    .start_i (s1_start_r),
    .info_o  (info)
  );

  thfd_scale u_temp_scale (
    .raw_i   (info.temp_word),
    .scale_i (TEMP_SCALE),
    .quot_o  (temp_q)
  );

  thfd_scale u_humid_scale (
    .raw_i   (info.humid_word),
    .scale_i (HUMID_SCALE),
    .quot_o  (humid_q)
  );

  assign frame_ok = (info.status == ST_OK);

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (step) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (step && info.last) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the byte beat.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r  <= in_rx_byte;
      s1_start_r <= in_frame_start;
    end
  end

  // Load the result; a CRC failure zeroes both readings. The offset wraps in
  // 15 bits, which gives the signed centidegree value directly.
  always_ff @(posedge clk) begin
    if (step && info.last) begin
      temp_r   <= frame_ok ? (temp_q - TEMP_OFFSET) : 15'd0;
      humid_r  <= frame_ok ? humid_q[13:0] : 14'd0;
      status_r <= info.status;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_temp_centideg  = signed'(temp_r);
  assign out_humid_centipct = humid_r;
  assign out_frame_status   = status_r;

  `TH_ASSERT_IMPL(a_stall_needs_byte, in_stall, s1_valid_r && info.last && out_valid_r)
  `TH_ASSERT_IMPL(a_bad_crc_zeroes, out_valid && (out_frame_status != ST_OK),
                  (out_temp_centideg == 15'sd0) && (out_humid_centipct == 14'd0))
  `TH_ASSERT_IMPL(a_humid_range, out_valid, out_humid_centipct <= 14'd10000)
  `TH_ASSERT_NEXT(a_result_after_close, step && info.last, out_valid)

endmodule

// ----- design/thfd_frame_ctrl.sv -----
// Frame tracker: byte position, running CRC and raw word holds.
// Depends on thfd_pkg.
module thfd_frame_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step_i,
  input  logic [7:0]            byte_i,
  input  logic                  start_i,
  output thfd_pkg::frame_info_t info_o
);
  import thfd_pkg::*;

  logic [2:0]  pos_r,   pos_nxt;
  logic [7:0]  crc_r,   crc_nxt;
  logic [7:0]  hi_r,    hi_nxt;
  logic [15:0] tword_r, tword_nxt;
  logic [15:0] hword_r, hword_nxt;
  logic        tgood_r, tgood_nxt;
  logic [2:0]  pos;
  logic        hum_ok;

  always_comb begin
    pos = start_i ? POS_T_HI : pos_r;
    if (pos > POS_H_CRC) begin
      pos = POS_T_HI;
    end
    hum_ok    = (byte_i == crc_r);
    crc_nxt   = crc_r;
    hi_nxt    = hi_r;
    tword_nxt = tword_r;
    hword_nxt = hword_r;
    tgood_nxt = tgood_r;
    case (pos)
      POS_T_HI, POS_H_HI: begin
        crc_nxt = crc8_update(CRC_INIT, byte_i);
        hi_nxt  = byte_i;
      end
      POS_T_LO: begin
        crc_nxt   = crc8_update(crc_r, byte_i);
        tword_nxt = {hi_r, byte_i};
      end
      POS_H_LO: begin
        crc_nxt   = crc8_update(crc_r, byte_i);
        hword_nxt = {hi_r, byte_i};
      end
      POS_T_CRC: begin
        tgood_nxt = (byte_i == crc_r);
        crc_nxt   = CRC_INIT;
      end
      default: begin
        crc_nxt = CRC_INIT;
      end
    endcase
    pos_nxt = (pos >= POS_H_CRC) ? POS_T_HI : pos + 3'd1;
  end

  always_comb begin
    info_o.last       = (pos == POS_H_CRC);
    info_o.temp_word  = tword_r;
    info_o.humid_word = hword_r;
    if (!tgood_r) begin
      info_o.status = ST_TEMP_CRC;
    end else if (!hum_ok) begin
      info_o.status = ST_HUMID_CRC;
    end else begin
      info_o.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= POS_T_HI;
      crc_r   <= CRC_INIT;
      hi_r    <= '0;
      tword_r <= '0;
      hword_r <= '0;
      tgood_r <= 1'b0;
    end else if (step_i) begin
      pos_r   <= pos_nxt;
      crc_r   <= crc_nxt;
      hi_r    <= hi_nxt;
      tword_r <= tword_nxt;
      hword_r <= hword_nxt;
      tgood_r <= tgood_nxt;
    end
  end

endmodule

// ----- design/thfd_scale.sv -----
// Scaler: floor(scale * raw / 65535) by multiply, shift and one correction.
// Depends on nothing outside this file.
module thfd_scale (
  input  logic [15:0] raw_i,
  input  logic [14:0] scale_i,
  output logic [14:0] quot_o
);
  logic [30:0] prod;
  logic [14:0] q0;
  logic [16:0] rem;

  // p = q0*65536 + lo, so p - q0*65535 = lo + q0, which stays below 2*65535.
  always_comb begin
    prod   = 31'(raw_i) * 31'(scale_i);
    q0     = prod[30:16];
    rem    = {1'b0, prod[15:0]} + {2'b00, q0};
    quot_o = q0 + {14'd0, (rem >= 17'd65535)};
  end

endmodule

// ----- tb/thfd_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the temperature/humidity frame decoder: tracks every byte beat,
// predicts the reading each frame closes with, and compares it to the result beats.
// Depends on thfd_pkg for the status codes and the byte positions.
module thfd_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  input  logic               in_frame_start,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [14:0] out_temp_centideg,
  input  logic [13:0]        out_humid_centipct,
  input  logic [1:0]         out_frame_status,
  output int                 fail_count,
  output int                 pending_count,
  output int                 checked_count,
  output int                 bad_crc_count
);
  import thfd_pkg::*;

  localparam logic [7:0] CRC_GEN   = 8'h31;
  localparam logic [7:0] CRC_SEED  = 8'hFF;
  localparam int         TEMP_SPAN = 17500;
  localparam int         TEMP_BASE = 4500;
  localparam int         HUMID_SPAN = 10000;
  localparam int         RAW_FULL  = 65535;

  typedef struct {
    logic signed [14:0] temp;
    logic [13:0]        humid;
    status_t            status;
  } reading_t;

  reading_t   readings_q[$];

  // Shadow of the decoder state.
  logic [2:0]  frame_pos;
  logic [7:0]  crc_acc;
  logic [7:0]  hi_byte;
  logic [15:0] temp_raw;
  logic [15:0] humid_raw;
  logic        temp_ok;

  int errors;
  int checked;
  int bad_crc;

  initial begin
    fail_count    = 0;
    pending_count = 0;
    checked_count = 0;
    bad_crc_count = 0;
    errors        = 0;
    checked       = 0;
    bad_crc       = 0;
  end

  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    repeat (8) c = c[7] ? ({c[6:0], 1'b0} ^ CRC_GEN) : {c[6:0], 1'b0};
    return c;
  endfunction

  task automatic log_failure(input string msg);
    $display("%0t ns: %s", $time, msg);
    errors++;
  endtask

  // Advance the shadow state by one byte; queue a reading when the frame closes.
  task automatic decode_byte(input logic [7:0] b, input logic first);
    logic [2:0] pos;
    logic       humid_ok;
    int         scaled;
    reading_t   r;
    pos = first ? POS_T_HI : frame_pos;
    if (pos > POS_H_CRC) pos = POS_T_HI;
    case (pos)
      POS_T_HI, POS_H_HI: begin
        crc_acc = crc8_next(CRC_SEED, b);
        hi_byte = b;
      end
      POS_T_LO: begin
        crc_acc  = crc8_next(crc_acc, b);
        temp_raw = {hi_byte, b};
      end
      POS_H_LO: begin
        crc_acc   = crc8_next(crc_acc, b);
        humid_raw = {hi_byte, b};
      end
      POS_T_CRC: begin
        temp_ok = (b == crc_acc);
        crc_acc = CRC_SEED;
      end
      default: begin
        humid_ok = (b == crc_acc);
        crc_acc  = CRC_SEED;
        r.temp   = '0;
        r.humid  = '0;
        if (!temp_ok) begin
          r.status = ST_TEMP_CRC;
        end else if (!humid_ok) begin
          r.status = ST_HUMID_CRC;
        end else begin
          r.status = ST_OK;
          scaled   = (TEMP_SPAN * int'(temp_raw)) / RAW_FULL - TEMP_BASE;
          r.temp   = scaled[14:0];
          scaled   = (HUMID_SPAN * int'(humid_raw)) / RAW_FULL;
          r.humid  = scaled[13:0];
        end
        readings_q.push_back(r);
      end
    endcase
    frame_pos = (pos == POS_H_CRC) ? POS_T_HI : pos + 3'd1;
  endtask

  always @(posedge clk) begin
    reading_t want;
    if (!rst_n) begin
      frame_pos = POS_T_HI;
      crc_acc   = CRC_SEED;
      hi_byte   = '0;
      temp_raw  = '0;
      humid_raw = '0;
      temp_ok   = 1'b0;
      readings_q.delete();
    end else begin
      if (in_valid && !in_stall) decode_byte(in_rx_byte, in_frame_start);
      if (out_valid && !out_stall) begin
        if (readings_q.size() == 0) begin
          log_failure($sformatf("result beat with none expected: temp %0d humid %0d status %0d",
                                out_temp_centideg, out_humid_centipct, out_frame_status));
        end else begin
          want = readings_q.pop_front();
          checked++;
          if (want.status != ST_OK) bad_crc++;
          if (out_temp_centideg !== want.temp)
            log_failure($sformatf("temp_centideg got %0d expected %0d",
                                  out_temp_centideg, want.temp));
          if (out_humid_centipct !== want.humid)
            log_failure($sformatf("humid_centipct got %0d expected %0d",
                                  out_humid_centipct, want.humid));
          if (out_frame_status !== want.status)
            log_failure($sformatf("frame_status got %0d expected %0d",
                                  out_frame_status, want.status));
        end
      end
    end
    fail_count    <= errors;
    pending_count <= readings_q.size();
    checked_count <= checked;
    bad_crc_count <= bad_crc;
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Top of the frame decoder testbench: clock, reset, byte stimulus, random result
// stalls, watchdog and verdict. Depends on thfd_pkg, thfd_checker and the decoder.
module tb_top;
  import thfd_pkg::*;

  localparam int IDLE_PCT      = 22;    // chance of a gap or a stall per cycle
  localparam int WATCHDOG_MAX  = 2000;  // cycles without any beat before giving up
  localparam int DRAIN_CYCLES  = 8;     // settle time after the last reading

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_rx_byte = 8'h00;
  logic               in_frame_start = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [14:0] out_temp_centideg;
  logic [13:0]        out_humid_centipct;
  logic [1:0]         out_frame_status;

  int fail_count;
  int pending_count;
  int checked_count;
  int bad_crc_count;

  // Random gaps on the byte side and stalls on the result side share one switch.
  logic gaps_on = 1'b1;
  int   bytes_sent = 0;
  int   starts_sent = 0;
  int   quiet_cycles = 0;

  temp_humidity_frame_decoder dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .in_frame_start    (in_frame_start),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_temp_centideg (out_temp_centideg),
    .out_humid_centipct(out_humid_centipct),
    .out_frame_status  (out_frame_status)
  );

  thfd_checker chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .in_frame_start    (in_frame_start),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_temp_centideg (out_temp_centideg),
    .out_humid_centipct(out_humid_centipct),
    .out_frame_status  (out_frame_status),
    .fail_count        (fail_count),
    .pending_count     (pending_count),
    .checked_count     (checked_count),
    .bad_crc_count     (bad_crc_count)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Stall the result side at random while gaps are enabled; hold it open otherwise.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= gaps_on && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Count cycles with no beat on either channel; give up when the count runs out.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_MAX) begin
        $display("watchdog: no beat for %0d cycles, %0d readings outstanding",
                 quiet_cycles, pending_count);
        $display("tb_top failed");
        $finish;
      end
    end
  end

  // CRC-8 over a whole 16-bit word, one bit at a time, MSB first.
  function automatic logic [7:0] word_crc(input logic [15:0] w);
    logic [7:0] c;
    logic       fb;
    c = CRC_INIT;
    for (int i = 15; i >= 0; i--) begin
      fb = c[7] ^ w[i];
      c  = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return c;
  endfunction

  // Corrupt a CRC byte unless it is meant to be good.
  function automatic logic [7:0] crc_byte(input logic [15:0] w, input bit good);
    return good ? word_crc(w) : word_crc(w) ^ 8'($urandom_range(255, 1));
  endfunction

  // Bias raw words toward the ends of the scale.
  function automatic logic [15:0] pick_word();
    case ($urandom_range(9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(15));
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  // Drive one byte beat; insert random gaps first and hold the payload while stalled.
  task automatic send_byte(input logic [7:0] b, input logic first);
    while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_rx_byte     <= b;
    in_frame_start <= first;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    if (first) starts_sent++;
  endtask

  // Send a full six-byte frame: temperature word and CRC, then humidity word and CRC.
  task automatic send_frame(input logic [15:0] t, input logic [15:0] h,
                            input bit t_good, input bit h_good, input logic first);
    send_byte(t[15:8], first);
    send_byte(t[7:0], 1'b0);
    send_byte(crc_byte(t, t_good), 1'b0);
    send_byte(h[15:8], 1'b0);
    send_byte(h[7:0], 1'b0);
    send_byte(crc_byte(h, h_good), 1'b0);
  endtask

  // Mostly well-formed frames with random content; the rest is loose bytes
  // with stray start flags that break frames apart.
  task automatic send_random(input int n_bytes);
    int stop_at;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(99) < 85) begin
        send_frame(pick_word(), pick_word(), $urandom_range(99) < 85,
                   $urandom_range(99) < 85, $urandom_range(99) < 80);
      end else begin
        repeat ($urandom_range(5, 1))
          send_byte(8'($urandom_range(255)), $urandom_range(99) < 15);
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: scale ends with good CRCs (lowest and highest readings).
    send_frame(16'h0000, 16'h0000, 1'b1, 1'b1, 1'b1);
    // Continue the position count without a start flag.
    send_frame(16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b0);
    // Drop a partial frame: restart mid-frame into one with both CRCs wrong,
    // which must report the temperature failure.
    send_byte(8'h12, 1'b1);
    send_byte(8'h34, 1'b0);
    send_frame(16'h8000, 16'h4000, 1'b0, 1'b0, 1'b1);
    // Good temperature, bad humidity.
    send_frame(16'h6666, 16'h1234, 1'b1, 1'b0, 1'b1);

    send_random(320);

    // Hold the byte side until every expected reading has come out.
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);

    // Long stretch at full rate on both sides.
    gaps_on <= 1'b0;
    send_random(260);
    gaps_on <= 1'b1;
    send_random(300);

    // Drain: wait for the last reading, then let the pipeline settle.
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d byte beats with %0d start flags, including scale ends, restarts",
             bytes_sent, starts_sent);
    $display("and a drain pause; %0d readings compared, %0d of them with a CRC failure.",
             checked_count, bad_crc_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/thfd_pkg.sv
design/thfd_frame_ctrl.sv
design/thfd_scale.sv
design/temp_humidity_frame_decoder.sv
tb/thfd_checker.sv
tb/tb_top.sv
